// ===== sv/rlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared widths, constants and types of the RMS level meter.
// ----------------------------------------------------------------------------
package rlm_pkg;

    localparam int MAX_BLOCK_SAMPLES = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 7;
    localparam int CNT_OUT_W  = 13;
    localparam int CNT_W      = $clog2(MAX_BLOCK_SAMPLES + 1);

    // full scale 32768, squared: the level compare works in units of 2^30
    localparam int FS_SHIFT   = 2 * (SAMPLE_W - 1);
    localparam int SUM_W      = FS_SHIFT + CNT_W;

    localparam int LEVEL_SCALE = 10000;
    localparam int SCALE_W    = $clog2(LEVEL_SCALE + 1);
    localparam int ACC_W      = SUM_W + SCALE_W;
    localparam int Q_W        = ACC_W - FS_SHIFT;
    localparam int MUL_W      = (SAMPLE_W > SCALE_W) ? SAMPLE_W : SCALE_W;

    localparam int LVL_SQ_W   = 2 * LEVEL_W;
    localparam int PROD_W     = LVL_SQ_W + CNT_W;
    localparam int BIT_W      = $clog2(LEVEL_W);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(100);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_rlm_in;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [CNT_OUT_W-1:0] sample_count;
        logic                 overflow;
    } t_rlm_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_SRCH_SQ,
        ST_SRCH_MUL,
        ST_SRCH_CMP
    } t_rlm_state;

    typedef struct packed {
        logic             load;
        logic [ACC_W-1:0] acc_init;
        logic [ACC_W-1:0] mcand;
        logic [MUL_W-1:0] mplier;
    } t_mac_ctrl;

endpackage

// ===== sv/rms_level_meter_unit.sv =====
// ----------------------------------------------------------------------------
// rms_level_meter_unit
// RMS level of a block of signed 16-bit PCM samples, scaled to 0..100.
// ----------------------------------------------------------------------------
// Usage: drive i_data and raise i_start; the sample is taken at a clock edge
// where i_start is high and o_busy is low. The sample marked last closes the
// block. One result per block appears on o_data, marked by o_done for exactly
// one cycle; the receiver has to take it then, there is no back-pressure.
// Each sample is squared by a bit-serial shift-add unit, one magnitude bit per
// cycle: o_busy stays high until the unit has run out of multiplier bits, so
// a zero sample is quickest and a full-scale one slowest. Samples past
// MAX_BLOCK_SAMPLES are not added and only set the overflow flag; o_busy stays
// low for them unless one is the last sample. On the last sample the same
// unit scales the sum by 10000, then a binary search picks the level one bit
// per step, each step through states ST_SRCH_SQ, ST_SRCH_MUL and ST_SRCH_CMP;
// o_done rises in the cycle after the last step, and a new sample may be
// taken in that cycle. The square-and-add loop therefore sets the rate: a new
// sample is taken only once the last one has been added, in an idle cycle.
// Reset (synchronous, active low) clears the sum, count and overflow flag
// and leaves the block idle.
// ----------------------------------------------------------------------------
module rms_level_meter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rlm_pkg::t_rlm_in  i_data,
    output logic              o_busy,
    output logic              o_done,
    output rlm_pkg::t_rlm_out o_data
);
    import rlm_pkg::*;

    t_rlm_state r_state, n_state;

    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic               r_last, n_last;
    logic [LEVEL_W-1:0] r_k, n_k;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [LVL_SQ_W-1:0] r_sq, n_sq;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic               r_done, n_done;
    logic [LEVEL_W-1:0] r_last_level, n_last_level;
    logic [CNT_OUT_W-1:0] r_out_cnt, n_out_cnt;
    logic               r_out_ovf, n_out_ovf;

    t_mac_ctrl          w_mac;
    logic [ACC_W-1:0]   w_acc;
    logic               w_mac_idle;

    logic               w_accept;
    logic               w_room;
    logic [SAMPLE_W-1:0] w_mag;
    logic [LEVEL_W-1:0] w_trial;
    logic [Q_W-1:0]     w_q;
    logic               w_fit;

    rlm_shift_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac),
        .o_acc   (w_acc),
        .o_idle  (w_mac_idle)
    );

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_room   = (r_cnt < CNT_W'(MAX_BLOCK_SAMPLES));
    assign w_mag    = i_data.sample[SAMPLE_W-1] ? (~i_data.sample + SAMPLE_W'(1))
                                                : i_data.sample;
    assign w_trial  = r_k | (LEVEL_W'(1) << r_bit);
    assign w_q      = w_acc[ACC_W-1:FS_SHIFT];
    assign w_fit    = (r_prod <= PROD_W'(w_q)) && (w_trial <= LEVEL_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_state = ST_SQUARE;
                    end else if (i_data.last) begin
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_SQUARE: begin
                if (w_mac_idle) begin
                    n_state = r_last ? ST_SCALE : ST_IDLE;
                end
            end
            ST_SCALE: begin
                if (w_mac_idle) begin
                    n_state = ST_SRCH_SQ;
                end
            end
            ST_SRCH_SQ:  n_state = ST_SRCH_MUL;
            ST_SRCH_MUL: n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                n_state = (r_bit == '0) ? ST_IDLE : ST_SRCH_SQ;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_ovf        = r_ovf;
        n_last       = r_last;
        n_k          = r_k;
        n_bit        = r_bit;
        n_sq         = r_sq;
        n_prod       = r_prod;
        n_done       = 1'b0;
        n_last_level = r_last_level;
        n_out_cnt    = r_out_cnt;
        n_out_ovf    = r_out_ovf;
        w_mac        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_last = i_data.last;
                    n_k    = '0;
                    n_bit  = BIT_W'(LEVEL_W - 1);
                    if (w_room) begin
                        n_cnt          = r_cnt + CNT_W'(1);
                        w_mac.load     = 1'b1;
                        w_mac.acc_init = ACC_W'(r_sum);
                        w_mac.mcand    = ACC_W'(w_mag);
                        w_mac.mplier   = MUL_W'(w_mag);
                    end else begin
                        n_ovf = 1'b1;
                        if (i_data.last) begin
                            // skip the add, scale the sum as it stands
                            w_mac.load   = 1'b1;
                            w_mac.mcand  = ACC_W'(r_sum);
                            w_mac.mplier = MUL_W'(LEVEL_SCALE);
                        end
                    end
                end
            end
            ST_SQUARE: begin
                if (w_mac_idle) begin
                    n_sum = w_acc[SUM_W-1:0];
                    if (r_last) begin
                        w_mac.load   = 1'b1;
                        w_mac.mcand  = w_acc;
                        w_mac.mplier = MUL_W'(LEVEL_SCALE);
                    end
                end
            end
            ST_SCALE: begin
            end
            ST_SRCH_SQ: begin
                n_sq = LVL_SQ_W'(w_trial) * LVL_SQ_W'(w_trial);
            end
            ST_SRCH_MUL: begin
                n_prod = PROD_W'(r_sq) * PROD_W'(r_cnt);
            end
            ST_SRCH_CMP: begin
                if (w_fit) begin
                    n_k = w_trial;
                end
                if (r_bit == '0) begin
                    // close the block: publish and clear
                    n_last_level = w_fit ? w_trial : r_k;
                    n_out_cnt    = CNT_OUT_W'(r_cnt);
                    n_out_ovf    = r_ovf;
                    n_done       = 1'b1;
                    n_sum        = '0;
                    n_cnt        = '0;
                    n_ovf        = 1'b0;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_done       <= 1'b0;
            r_last_level <= '0;
        end else begin
            r_state      <= n_state;
            r_sum        <= n_sum;
            r_cnt        <= n_cnt;
            r_ovf        <= n_ovf;
            r_done       <= n_done;
            r_last_level <= n_last_level;
        end
        r_last    <= n_last;
        r_k       <= n_k;
        r_bit     <= n_bit;
        r_sq      <= n_sq;
        r_prod    <= n_prod;
        r_out_cnt <= n_out_cnt;
        r_out_ovf <= n_out_ovf;
    end

    assign o_busy              = (r_state != ST_IDLE);
    assign o_done              = r_done;
    assign o_data.level        = r_last_level;
    assign o_data.sample_count = r_out_cnt;
    assign o_data.overflow     = r_out_ovf;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == ST_IDLE))
        else $error("result strobe outside idle");

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_data.level <= LEVEL_MAX))
        else $error("level above full scale");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BLOCK_SAMPLES))
        else $error("sample count past block limit");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result strobes");

    a_mac_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> w_mac_idle)
        else $error("shift-add unit running while idle");

endmodule

// ===== sv/rlm_shift_mac.sv =====
// ----------------------------------------------------------------------------
// rlm_shift_mac
// Bit-serial multiply-accumulate: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rlm_shift_mac (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rlm_pkg::t_mac_ctrl         i_ctrl,
    output logic [rlm_pkg::ACC_W-1:0]  o_acc,
    output logic                       o_idle
);
    import rlm_pkg::*;

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] r_mcand, n_mcand;
    logic [MUL_W-1:0] r_mplier, n_mplier;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_ctrl.load) begin
            n_acc    = i_ctrl.acc_init;
            n_mcand  = i_ctrl.mcand;
            n_mplier = i_ctrl.mplier;
        end else if (r_mplier != '0) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else begin
            r_mplier <= n_mplier;
        end
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
    end

    assign o_acc  = r_acc;
    assign o_idle = (r_mplier == '0);

endmodule
